// ----- rtl/bb3_pkg.sv -----
package bb3_pkg;

    // sizing
    localparam int MAX_WIDTH       = 2048;
    localparam int CHANNEL_BITS    = 8;
    localparam int NUM_CH          = 3;
    localparam int COL_BITS        = $clog2(MAX_WIDTH);

    // configuration registers
    localparam int WIDTH_REG_BITS  = 12;
    localparam int HEIGHT_REG_BITS = 16;
    localparam int CFG_DATA_BITS   = 16;
    localparam int WIDTH_RESET     = 640;
    localparam int HEIGHT_RESET    = 480;
    localparam int CMP_BITS        = (COL_BITS + 1 > WIDTH_REG_BITS) ? COL_BITS + 1
                                                                      : WIDTH_REG_BITS;

    // arithmetic widths
    localparam int COLSUM_BITS     = CHANNEL_BITS + 2;
    localparam int SUM_BITS        = CHANNEL_BITS + 4;

    // divide by nine as multiply by reciprocal, exact for every sum below 9 * 2**CHANNEL_BITS
    localparam int DIV_SHIFT       = SUM_BITS + 3;
    localparam int DIV_MULT        = (2 ** DIV_SHIFT + 8) / 9;
    localparam int MULT_BITS       = SUM_BITS + 1;
    localparam int PROD_BITS       = SUM_BITS + MULT_BITS;

    // result queue
    localparam int FIFO_DEPTH      = 8;
    localparam int FIFO_PTR_BITS   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS   = FIFO_PTR_BITS + 1;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // channel 2 red, 1 green, 0 blue
    typedef logic [NUM_CH-1:0][CHANNEL_BITS-1:0] pixel_t;
    typedef logic [NUM_CH-1:0][COLSUM_BITS-1:0]  colsum_t;
    typedef logic [NUM_CH-1:0][SUM_BITS-1:0]     wsum_t;

    typedef struct packed {
        pixel_t upper;
        pixel_t middle;
    } line_word_t;

    typedef struct packed {
        logic emit_inner;
        logic emit_border;
        logic frame_end;
    } emit_t;

    typedef struct packed {
        pixel_t mean;
        logic   frame_end;
    } result_t;

    function automatic logic [CHANNEL_BITS-1:0] div9(input logic [SUM_BITS-1:0] sum);
        logic [PROD_BITS-1:0] prod;
        prod = PROD_BITS'(sum) * PROD_BITS'(DIV_MULT);
        return prod[DIV_SHIFT +: CHANNEL_BITS];
    endfunction

endpackage

// ----- rtl/bb3_ram.sv -----
module bb3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // single write port, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/box_blur_3x3_rgb.sv -----
// 3x3 box blur over an rgb raster stream, zero padding outside the frame
// throughput: one pixel or drain tick per cycle while s_ready is high; up to two results
// per item, one out per cycle while m_ready is high; each result passes the line memory
// read, column sums, window sums and divide by nine, then waits in the result queue
// reset: config returns to 640 x 480, then a pass over all 2048 entries zeroes the line memory
// with s_ready low; configuration writes are taken throughout
module box_blur_3x3_rgb (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_wr_en,
    input  logic                                 cfg_index,
    input  logic [bb3_pkg::CFG_DATA_BITS-1:0]    cfg_data,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_mode,
    input  logic [bb3_pkg::CHANNEL_BITS-1:0]     s_red,
    input  logic [bb3_pkg::CHANNEL_BITS-1:0]     s_green,
    input  logic [bb3_pkg::CHANNEL_BITS-1:0]     s_blue,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [bb3_pkg::CHANNEL_BITS-1:0]     m_red_mean,
    output logic [bb3_pkg::CHANNEL_BITS-1:0]     m_green_mean,
    output logic [bb3_pkg::CHANNEL_BITS-1:0]     m_blue_mean,
    output logic                                 m_frame_end
);

    localparam int CB   = bb3_pkg::CHANNEL_BITS;
    localparam int CLB  = bb3_pkg::COL_BITS;
    localparam int CMPB = bb3_pkg::CMP_BITS;
    localparam int HB   = bb3_pkg::HEIGHT_REG_BITS;
    localparam int WB   = bb3_pkg::WIDTH_REG_BITS;
    localparam int CSB  = bb3_pkg::COLSUM_BITS;
    localparam int SB   = bb3_pkg::SUM_BITS;
    localparam int FPB  = bb3_pkg::FIFO_PTR_BITS;
    localparam int FCB  = bb3_pkg::FIFO_CNT_BITS;

    // configuration
    logic [WB-1:0]   image_width_reg;
    logic [HB-1:0]   image_height_reg;
    logic [CMPB-1:0] width_ext;
    logic [CMPB-1:0] width_eff;
    logic [CMPB-1:0] width_last;
    logic [HB-1:0]   height_eff;

    // position and admission
    logic [CLB-1:0]  col_count_reg;
    logic [HB-1:0]   row_count_reg;
    logic            clear_active_reg;
    logic [CLB-1:0]  clear_addr_reg;
    logic [FCB-1:0]  committed_reg;
    logic [FCB-1:0]  committed_next;
    logic            in_xfer;
    logic            out_xfer;
    logic            col_at_end;
    logic            row_in_drain;
    logic            row_top;
    logic [1:0]      n_results;
    bb3_pkg::emit_t  emit_in;
    bb3_pkg::pixel_t pix_in;

    // line memory
    logic                       ram_we;
    logic [CLB-1:0]             ram_waddr;
    logic [$bits(bb3_pkg::line_word_t)-1:0] ram_wdata;
    logic [$bits(bb3_pkg::line_word_t)-1:0] ram_rdata;

    // stage 1: line read and column sums
    logic                 s1_valid_reg;
    logic [CLB-1:0]       s1_col_reg;
    logic                 s1_top_reg;
    bb3_pkg::pixel_t      s1_pix_reg;
    bb3_pkg::emit_t       s1_emit_reg;
    logic                 s1_fwd_reg;
    bb3_pkg::line_word_t  s1_fwd_data_reg;
    bb3_pkg::line_word_t  line_rd;
    bb3_pkg::line_word_t  wr_word;
    bb3_pkg::pixel_t      up_pix;
    bb3_pkg::pixel_t      mid_pix;
    bb3_pkg::colsum_t     col_new;
    bb3_pkg::colsum_t     win_reg [3];

    // stage 2: window sums
    logic                 s2_valid_reg;
    bb3_pkg::emit_t       s2_emit_reg;
    bb3_pkg::wsum_t       sum_all;
    bb3_pkg::wsum_t       sum_right;

    // stage 3: divide and queue
    logic                 s3_valid_reg;
    bb3_pkg::emit_t       s3_emit_reg;
    bb3_pkg::wsum_t       s3_sum_all_reg;
    bb3_pkg::wsum_t       s3_sum_right_reg;
    bb3_pkg::result_t     res_inner;
    bb3_pkg::result_t     res_border;

    // result queue
    bb3_pkg::result_t     fifo_reg [bb3_pkg::FIFO_DEPTH];
    logic [FPB-1:0]       fifo_wr_ptr_reg;
    logic [FPB-1:0]       fifo_rd_ptr_reg;
    logic [FCB-1:0]       fifo_count_reg;
    logic                 fifo_wr0;
    logic                 fifo_wr1;
    bb3_pkg::result_t     fifo_wr0_data;
    bb3_pkg::result_t     fifo_head;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= WB'(bb3_pkg::WIDTH_RESET);
            image_height_reg <= HB'(bb3_pkg::HEIGHT_RESET);
        end else if (cfg_wr_en) begin
            case (bb3_pkg::cfg_reg_t'(cfg_index))
                bb3_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[WB-1:0];
                bb3_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[HB-1:0];
                default: ;
            endcase
        end
    end

    // effective frame size
    always_comb begin
        width_ext = CMPB'(image_width_reg);
        if (width_ext == '0) begin
            width_eff = CMPB'(1);
        end else if (width_ext > CMPB'(bb3_pkg::MAX_WIDTH)) begin
            width_eff = CMPB'(bb3_pkg::MAX_WIDTH);
        end else begin
            width_eff = width_ext;
        end
        width_last = width_eff - CMPB'(1);
        height_eff = (image_height_reg == '0) ? HB'(1) : image_height_reg;
    end

    // position decode for the incoming item
    always_comb begin
        col_at_end   = CMPB'(col_count_reg) >= width_last;
        row_in_drain = row_count_reg >= height_eff;
        row_top      = row_count_reg == '0;
        emit_in.emit_inner  = !row_top && (col_count_reg != '0);
        emit_in.emit_border = !row_top && col_at_end;
        emit_in.frame_end   = row_in_drain;
        n_results = {1'b0, emit_in.emit_inner} + {1'b0, emit_in.emit_border};
        pix_in[2] = s_red;
        pix_in[1] = s_green;
        pix_in[0] = s_blue;
        if (s_mode || row_in_drain) begin
            pix_in = '0;
        end
    end

    // admission: room in the queue for every result already promised
    assign s_ready  = !clear_active_reg
                      && (committed_reg <= FCB'(bb3_pkg::FIFO_DEPTH - 2));
    assign in_xfer  = s_valid && s_ready;
    assign out_xfer = m_valid && m_ready;

    always_comb begin
        committed_next = committed_reg;
        if (in_xfer) begin
            committed_next = committed_next + FCB'(n_results);
        end
        if (out_xfer) begin
            committed_next = committed_next - FCB'(1);
        end
    end

    // counters, clearing pass and stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg    <= '0;
            row_count_reg    <= '0;
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
            committed_reg    <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
        end else begin
            committed_reg <= committed_next;
            s1_valid_reg  <= in_xfer;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            if (clear_active_reg) begin
                clear_addr_reg <= clear_addr_reg + CLB'(1);
                if (clear_addr_reg == CLB'(bb3_pkg::MAX_WIDTH - 1)) begin
                    clear_active_reg <= 1'b0;
                end
            end
            if (in_xfer) begin
                if (col_at_end) begin
                    col_count_reg <= '0;
                    row_count_reg <= row_in_drain ? '0 : row_count_reg + HB'(1);
                end else begin
                    col_count_reg <= col_count_reg + CLB'(1);
                end
            end
        end
    end

    // capture item; forward the entry stage 1 writes this cycle if it is read again
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            s1_col_reg      <= col_count_reg;
            s1_top_reg      <= row_top;
            s1_pix_reg      <= pix_in;
            s1_emit_reg     <= emit_in;
            s1_fwd_reg      <= s1_valid_reg && (s1_col_reg == col_count_reg);
            s1_fwd_data_reg <= wr_word;
        end
    end

    // line memory: upper and middle rows side by side
    assign ram_we    = clear_active_reg || s1_valid_reg;
    assign ram_waddr = clear_active_reg ? clear_addr_reg : s1_col_reg;
    assign ram_wdata = clear_active_reg ? '0 : wr_word;

    bb3_ram #(
        .WIDTH ($bits(bb3_pkg::line_word_t)),
        .DEPTH (bb3_pkg::MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (col_count_reg),
        .rd_data (ram_rdata)
    );

    // stage 1: rows above, line write-back and new column sum
    always_comb begin
        line_rd = s1_fwd_reg ? s1_fwd_data_reg : bb3_pkg::line_word_t'(ram_rdata);
        up_pix  = s1_top_reg ? '0 : line_rd.upper;
        mid_pix = s1_top_reg ? '0 : line_rd.middle;
        wr_word.upper  = mid_pix;
        wr_word.middle = s1_pix_reg;
        for (int ch = 0; ch < bb3_pkg::NUM_CH; ch++) begin
            col_new[ch] = CSB'(up_pix[ch]) + CSB'(mid_pix[ch]) + CSB'(s1_pix_reg[ch]);
        end
    end

    // window of three column sums, cleared at the start of each row
    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            if (s1_col_reg == '0) begin
                win_reg[0] <= '0;
                win_reg[1] <= '0;
            end else begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
            end
            win_reg[2] <= col_new;
            s2_emit_reg <= s1_emit_reg;
        end
    end

    // stage 2: full window and right two columns
    always_comb begin
        for (int ch = 0; ch < bb3_pkg::NUM_CH; ch++) begin
            sum_right[ch] = SB'(win_reg[1][ch]) + SB'(win_reg[2][ch]);
            sum_all[ch]   = sum_right[ch] + SB'(win_reg[0][ch]);
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_valid_reg) begin
            s3_sum_all_reg   <= sum_all;
            s3_sum_right_reg <= sum_right;
            s3_emit_reg      <= s2_emit_reg;
        end
    end

    // stage 3: divide by nine
    always_comb begin
        for (int ch = 0; ch < bb3_pkg::NUM_CH; ch++) begin
            res_inner.mean[ch]  = bb3_pkg::div9(s3_sum_all_reg[ch]);
            res_border.mean[ch] = bb3_pkg::div9(s3_sum_right_reg[ch]);
        end
        res_inner.frame_end  = 1'b0;
        res_border.frame_end = s3_emit_reg.frame_end;
        fifo_wr0 = s3_valid_reg && (s3_emit_reg.emit_inner || s3_emit_reg.emit_border);
        fifo_wr1 = s3_valid_reg && s3_emit_reg.emit_inner && s3_emit_reg.emit_border;
        fifo_wr0_data = s3_emit_reg.emit_inner ? res_inner : res_border;
    end

    // result queue, inner centre before border centre
    always_ff @(posedge aclk) begin
        if (fifo_wr0) begin
            fifo_reg[fifo_wr_ptr_reg] <= fifo_wr0_data;
        end
        if (fifo_wr1) begin
            fifo_reg[fifo_wr_ptr_reg + FPB'(1)] <= res_border;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fifo_wr_ptr_reg <= '0;
            fifo_rd_ptr_reg <= '0;
            fifo_count_reg  <= '0;
        end else begin
            fifo_wr_ptr_reg <= fifo_wr_ptr_reg + FPB'(fifo_wr0) + FPB'(fifo_wr1);
            fifo_rd_ptr_reg <= fifo_rd_ptr_reg + FPB'(out_xfer);
            fifo_count_reg  <= fifo_count_reg + FCB'(fifo_wr0) + FCB'(fifo_wr1)
                               - FCB'(out_xfer);
        end
    end

    // result channel
    assign fifo_head    = fifo_reg[fifo_rd_ptr_reg];
    assign m_valid      = fifo_count_reg != '0;
    assign m_red_mean   = fifo_head.mean[2];
    assign m_green_mean = fifo_head.mean[1];
    assign m_blue_mean  = fifo_head.mean[0];
    assign m_frame_end  = fifo_head.frame_end;

endmodule
